@@ design/agc_pkg.sv @@
// Shared types, constants and helpers for the audio AGC.
// Used by agc_mul, agc_div and audio_agc. No dependencies.
package agc_pkg;

	localparam int DATA_W    = 16;
	localparam int MULA_W    = DATA_W + 1;
	localparam int MUL_DIGIT = 4;
	localparam int MUL_STEPS = DATA_W / MUL_DIGIT;
	localparam int PROD_W    = 33;
	localparam int GAIN_FRAC = 12;
	localparam int DIV_BITS  = DATA_W;
	localparam int BLEND_SH  = 16;

	localparam logic [DATA_W-1:0] RST_ATTACK  = 16'd65263;
	localparam logic [DATA_W-1:0] RST_RELEASE = 16'd65519;
	localparam logic [DATA_W-1:0] RST_TARGET  = 16'd7209;
	localparam logic [DATA_W-1:0] RST_FLOOR   = 16'd655;
	localparam logic [DATA_W-1:0] RST_MIN_G   = 16'd1434;
	localparam logic [DATA_W-1:0] RST_MAX_G   = 16'd16384;
	localparam logic [DATA_W-1:0] RST_GAIN_W  = 16'd1966;
	localparam logic [DATA_W-1:0] UNITY_GAIN  = 16'd4096;

	typedef enum logic [2:0] {
		REG_ATTACK  = 3'd0,
		REG_RELEASE = 3'd1,
		REG_TARGET  = 3'd2,
		REG_FLOOR   = 3'd3,
		REG_MIN_G   = 3'd4,
		REG_MAX_G   = 3'd5,
		REG_GAIN_W  = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic                     start;
		logic signed [MULA_W-1:0] a;
		logic [DATA_W-1:0]        b;
	} mul_req_t;

	typedef struct packed {
		logic                     done;
		logic signed [PROD_W-1:0] prod;
	} mul_rsp_t;

	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] num;
		logic [DATA_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic              ovf;
		logic [DATA_W-1:0] quot;
	} div_rsp_t;

	// base + round(w*(a-base) / 2^16); exact form of the weighted blend
	function automatic logic [DATA_W-1:0] blend_fin(input logic [DATA_W-1:0] base,
			input logic signed [PROD_W-1:0] prod);
		logic signed [PROD_W-1:0] r;
		r = (prod + $signed(PROD_W'(32768))) >>> BLEND_SH;
		return base + r[DATA_W-1:0];
	endfunction

endpackage

@@ design/audio_agc.sv @@
// Top level of the feedforward audio AGC: config registers, sequencer, output register.
// Depends on agc_pkg, agc_mul and agc_div.
//
// Usage:
//  - Input channel: audio_in with in_valid / in_stall. A sample is taken when
//    in_valid is high and in_stall low; in_stall is high while a sample is in work.
//  - Output channel: audio_out and gain_now with out_valid / out_stall. One result
//    transaction per sample, held in an output register until taken.
//  - Config channel: cfg_index / cfg_data with cfg_valid / cfg_ready; cfg_ready
//    is always high. Indexes 0..6 select the seven registers, others are ignored.
//    Write only while no sample is in flight.
//  - Sequence: a sample takes three passes of the shared 4-bit digit multiplier
//    (envelope, gain blend, output) with the 16-bit serial divider between the
//    first two, then goes into the output register. A new sample is not taken
//    before the last one has left for the output register and the sequencer is idle.
//  - Out stall: a finished sample waits in work until the output register is free;
//    the next sample can be taken as soon as that one has moved to the output register.
//  - Reset: config registers take their defaults, envelope clears to zero,
//    applied gain goes to unity (4096), no result is pending.
module audio_agc import agc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [DATA_W-1:0] audio_in,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] audio_out,
	output logic [DATA_W-1:0]        gain_now,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [2:0]               cfg_index,
	input  logic [DATA_W-1:0]        cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ENV,
		ST_DIV,
		ST_GAIN,
		ST_OUT,
		ST_PUSH
	} state_t;

	localparam logic signed [PROD_W-1:0] SAT_HI = 32767;
	localparam logic signed [PROD_W-1:0] SAT_LO = -32768;

	state_t                   state_q;
	logic [DATA_W-1:0]        attack_q, release_q, target_q, floor_q;
	logic [DATA_W-1:0]        min_g_q, max_g_q, gain_w_q;
	logic [DATA_W-1:0]        env_q, gain_q;
	logic signed [DATA_W-1:0] x_q, y_q;
	logic signed [DATA_W-1:0] audio_out_q;
	logic [DATA_W-1:0]        gain_out_q;
	logic                     out_valid_q;

	logic                     accept;
	logic                     post_out;
	logic [DATA_W-1:0]        lvl, lvl_x, coef, env_new, flr, den, desired, gain_new;
	logic signed [PROD_W-1:0] ysh;
	logic signed [DATA_W-1:0] y_sat;
	mul_req_t                 mul_req;
	mul_rsp_t                 mul_rsp;
	div_req_t                 div_req;
	div_rsp_t                 div_rsp;

	assign in_stall  = state_q != ST_IDLE;
	assign accept    = in_valid && !in_stall;
	assign post_out  = (state_q == ST_PUSH) && (!out_valid_q || !out_stall);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign audio_out = audio_out_q;
	assign gain_now  = gain_out_q;

	assign lvl     = audio_in[DATA_W-1] ? (DATA_W'(0) - $unsigned(audio_in)) : $unsigned(audio_in);
	assign lvl_x   = x_q[DATA_W-1] ? (DATA_W'(0) - $unsigned(x_q)) : $unsigned(x_q);
	assign coef    = (lvl > env_q) ? attack_q : release_q;
	// coef weighs the old envelope: level + round(coef*(env-level) / 2^16)
	assign env_new = blend_fin(lvl_x, mul_rsp.prod);
	assign flr     = (floor_q == '0) ? DATA_W'(1) : floor_q;
	assign den     = (env_new > flr) ? env_new : flr;
	assign gain_new = blend_fin(gain_q, mul_rsp.prod);

	// quotient of 2^16 or more is above any max_gain
	always_comb begin
		if (div_rsp.ovf)
			desired = max_g_q;
		else if (div_rsp.quot < min_g_q)
			desired = min_g_q;
		else if (div_rsp.quot > max_g_q)
			desired = max_g_q;
		else
			desired = div_rsp.quot;
	end

	// round half up, then saturate to Q1.15
	assign ysh = (mul_rsp.prod + $signed(PROD_W'(2048))) >>> GAIN_FRAC;
	always_comb begin
		if (ysh > SAT_HI)
			y_sat = SAT_HI[DATA_W-1:0];
		else if (ysh < SAT_LO)
			y_sat = SAT_LO[DATA_W-1:0];
		else
			y_sat = ysh[DATA_W-1:0];
	end

	always_comb begin
		mul_req = '0;
		case (state_q)
			ST_IDLE: begin
				mul_req.start = accept;
				mul_req.a     = $signed({1'b0, env_q}) - $signed({1'b0, lvl});
				mul_req.b     = coef;
			end
			ST_DIV: begin
				mul_req.start = div_rsp.done;
				mul_req.a     = $signed({1'b0, desired}) - $signed({1'b0, gain_q});
				mul_req.b     = gain_w_q;
			end
			ST_GAIN: begin
				mul_req.start = mul_rsp.done;
				mul_req.a     = MULA_W'(x_q);
				mul_req.b     = gain_new;
			end
			default: begin
				mul_req = '0;
			end
		endcase
	end

	assign div_req.start = (state_q == ST_ENV) && mul_rsp.done;
	assign div_req.num   = target_q;
	assign div_req.den   = den;

	agc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	agc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q  <= RST_ATTACK;
			release_q <= RST_RELEASE;
			target_q  <= RST_TARGET;
			floor_q   <= RST_FLOOR;
			min_g_q   <= RST_MIN_G;
			max_g_q   <= RST_MAX_G;
			gain_w_q  <= RST_GAIN_W;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_ATTACK:  attack_q  <= cfg_data;
				REG_RELEASE: release_q <= cfg_data;
				REG_TARGET:  target_q  <= cfg_data;
				REG_FLOOR:   floor_q   <= cfg_data;
				REG_MIN_G:   min_g_q   <= cfg_data;
				REG_MAX_G:   max_g_q   <= cfg_data;
				REG_GAIN_W:  gain_w_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			env_q       <= '0;
			gain_q      <= UNITY_GAIN;
			x_q         <= '0;
			y_q         <= '0;
			audio_out_q <= '0;
			gain_out_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (post_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						x_q     <= audio_in;
						state_q <= ST_ENV;
					end
				end
				ST_ENV: begin
					if (mul_rsp.done) begin
						env_q   <= env_new;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_rsp.done)
						state_q <= ST_GAIN;
				end
				ST_GAIN: begin
					if (mul_rsp.done) begin
						gain_q  <= gain_new;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (mul_rsp.done) begin
						y_q     <= y_sat;
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (post_out) begin
						audio_out_q <= y_q;
						gain_out_q  <= gain_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("input taken while a sample is in work");

	a_env_bound: assert property (@(posedge clk) disable iff (!arst_n)
		env_q <= 16'd32768)
		else $error("envelope above full scale");

	a_out_from_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_PUSH))
		else $error("result posted outside push state");

endmodule

@@ design/agc_mul.sv @@
// Digit-serial signed x unsigned multiplier, MUL_DIGIT bits of b per cycle.
// Depends on agc_pkg.
module agc_mul import agc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mul_req_t req,
	output mul_rsp_t rsp
);

	localparam int CNT_W = $clog2(MUL_STEPS);

	logic signed [MULA_W-1:0]           a_q;
	logic [DATA_W-1:0]                  b_q;
	logic signed [PROD_W-1:0]           acc_q;
	logic [CNT_W-1:0]                   cnt_q;
	logic                               busy_q;
	logic                               done_q;
	logic signed [MULA_W+MUL_DIGIT-1:0] part;

	// Horner, most significant digit first
	assign part = a_q * $signed({1'b0, b_q[DATA_W-1 -: MUL_DIGIT]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(MUL_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a;
			b_q   <= req.b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= (acc_q <<< MUL_DIGIT) + PROD_W'(part);
			b_q   <= b_q << MUL_DIGIT;
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = acc_q;

	a_mul_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> ##(MUL_STEPS + 1) rsp.done)
		else $error("multiplier done not on schedule");

	a_mul_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !(cnt_q == CNT_W'(MUL_STEPS - 1)) |-> !req.start)
		else $error("multiplier restarted while busy");

endmodule

@@ design/agc_div.sv @@
// Restoring divider for the AGC gain: (num << GAIN_FRAC) / den, one quotient
// bit per cycle, with an overflow flag for quotients of 2^16 and above. Depends on agc_pkg.
module agc_div import agc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int OVF_SH = DATA_W - GAIN_FRAC;
	localparam int CNT_W  = $clog2(DIV_BITS);

	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] low_q;
	logic [DATA_W-1:0] den_q;
	logic [DATA_W-1:0] quot_q;
	logic              ovf_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DATA_W:0]   trial;
	logic              ge;

	assign trial = {rem_q, low_q[DATA_W-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			den_q  <= req.den;
			// partial remainder starts below den unless the quotient overflows
			rem_q  <= req.num >> OVF_SH;
			low_q  <= req.num << GAIN_FRAC;
			ovf_q  <= {{OVF_SH{1'b0}}, req.num} >= {req.den, {OVF_SH{1'b0}}};
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? DATA_W'(trial - {1'b0, den_q}) : trial[DATA_W-1:0];
			low_q  <= low_q << 1;
			quot_q <= {quot_q[DATA_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.ovf  = ovf_q;
	assign rsp.quot = quot_q;

	a_div_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> ##(DIV_BITS + 1) rsp.done)
		else $error("divider done not on schedule");

endmodule
